>>> hw/rtl/gpq_pkg.sv
// Package for the Groestl P/Q permutation block.
// Holds the AES S-box, GF(2^8) helpers, shift vectors and variant codes.
// No dependencies.
package gpq_pkg;

    typedef enum logic [1:0] {
        OP_P512  = 2'd0,
        OP_Q512  = 2'd1,
        OP_P1024 = 2'd2,
        OP_Q1024 = 2'd3
    } t_op;

    localparam int MAX_COLS = 16;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] tbl [0:255];
        tbl = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return tbl[a];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Row shift amount for variant and row
    function automatic logic [3:0] row_shift(input logic [1:0] v, input logic [2:0] r);
        logic [3:0] s;
        case (v)
            OP_P512:  s = {1'b0, r};
            OP_Q512:  s = {1'b0, r[1:0], 1'b1} & 4'h7;
            OP_P1024: s = (r == 3'd7) ? 4'd11 : {1'b0, r};
            default:  s = (r == 3'd3) ? 4'd11 : ({1'b0, r[1:0], 1'b1} & 4'h7);
        endcase
        if (v == OP_Q512 || v == OP_Q1024) begin
            if (r >= 3'd4) s = {1'b0, r[1:0], 1'b0};
        end
        return s;
    endfunction

    // One MixBytes column: circulant matrix (2,2,3,4,5,3,5,7)
    function automatic logic [63:0] mix_col(input logic [63:0] c);
        logic [7:0] b [8];
        logic [7:0] x1 [8];
        logic [7:0] x2 [8];
        logic [7:0] x4 [8];
        logic [7:0] acc;
        logic [7:0] m;
        logic [2:0] k3;
        logic [63:0] o;
        for (int k = 0; k < 8; k++) begin
            b[k]  = c[63-8*k -: 8];
            x1[k] = b[k];
            x2[k] = xt(b[k]);
            x4[k] = xt(x2[k]);
        end
        for (int i = 0; i < 8; i++) begin
            acc = 8'h00;
            for (int k = 0; k < 8; k++) begin
                k3 = 3'(k + 8 - i);
                case (k3)
                    3'd0, 3'd1: m = x2[k];
                    3'd2, 3'd5: m = x2[k] ^ x1[k];
                    3'd3:       m = x4[k];
                    3'd4, 3'd6: m = x4[k] ^ x1[k];
                    default:    m = x4[k] ^ x2[k] ^ x1[k];
                endcase
                acc ^= m;
            end
            o[63-8*i -: 8] = acc;
        end
        return o;
    endfunction

endpackage

>>> hw/rtl/groestl_permutation_pq.sv
// Groestl P/Q permutation, 512 and 1024 variants.
// After the last column is loaded, all rounds run column by column; then the
// result goes out one column per cycle while the sink is ready. One shared
// column unit (S-box + MixBytes) handles one column per cycle. Input is not
// ready during compute and output, so a new state waits for the last output.
// Reset (synchronous, active low) returns the sequencer to loading.
// Depends on gpq_pkg.
module groestl_permutation_pq (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,  // [1:0] op, [65:2] column_word, rest zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,  // [63:0] result_column
    output logic        o_m_axis_tlast   // last
);

    typedef enum logic [1:0] {ST_LOAD, ST_ROUND, ST_OUT} t_state;

    t_state      r_state;
    logic [4:0]  r_cnt;
    logic [3:0]  r_col;
    logic [3:0]  r_round;
    logic [1:0]  r_var;
    logic [63:0] r_m [gpq_pkg::MAX_COLS];
    logic [63:0] r_t [gpq_pkg::MAX_COLS];

    logic        w_wide, w_q;
    logic [3:0]  w_nm1, w_rmax;
    logic [63:0] w_col;

    assign w_wide = r_var[1];
    assign w_q    = r_var[0];
    assign w_nm1  = w_wide ? 4'd15 : 4'd7;
    assign w_rmax = w_wide ? 4'd13 : 4'd9;

    // Shared column unit: round constant, shift, S-box, MixBytes
    always_comb begin
        logic [3:0]  src;
        logic [63:0] s, g;
        logic [7:0]  b, rc;
        for (int i = 0; i < 8; i++) begin
            src = (r_col + gpq_pkg::row_shift(r_var, 3'(i))) & w_nm1;
            s   = r_m[src];
            b   = s[63-8*i -: 8];
            rc  = {src, r_round};
            if (w_q) begin
                b = ~b;
                if (i == 7) b = b ^ rc;
            end else if (i == 0) begin
                b = b ^ rc;
            end
            g[63-8*i -: 8] = gpq_pkg::sbox(b);
        end
        w_col = gpq_pkg::mix_col(g);
    end

    assign o_s_axis_tready = (r_state == ST_LOAD);
    assign o_m_axis_tvalid = (r_state == ST_OUT);
    assign o_m_axis_tdata  = r_m[r_col];
    assign o_m_axis_tlast  = (r_col == w_nm1);

    // Sequencer and state storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_col   <= '0;
            r_round <= '0;
            r_var   <= '0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (i_s_axis_tvalid) begin
                        logic [1:0] v;
                        v = (r_cnt == 5'd0) ? i_s_axis_tdata[1:0] : r_var;
                        r_var <= v;
                        r_m[r_cnt[3:0]] <= i_s_axis_tdata[65:2];
                        if (r_cnt[3:0] == (v[1] ? 4'd15 : 4'd7)) begin
                            r_cnt   <= '0;
                            r_col   <= '0;
                            r_round <= '0;
                            r_state <= ST_ROUND;
                        end else begin
                            r_cnt <= r_cnt + 5'd1;
                        end
                    end
                end
                ST_ROUND: begin
                    r_t[r_col] <= w_col;
                    if (r_col == w_nm1) begin
                        r_col <= '0;
                        for (int j = 0; j < gpq_pkg::MAX_COLS; j++) begin
                            r_m[j] <= (4'(j) == r_col) ? w_col : r_t[j];
                        end
                        if (r_round == w_rmax) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_round <= r_round + 4'd1;
                        end
                    end else begin
                        r_col <= r_col + 4'd1;
                    end
                end
                ST_OUT: begin
                    if (i_m_axis_tready) begin
                        if (r_col == w_nm1) begin
                            r_col   <= '0;
                            r_state <= ST_LOAD;
                        end else begin
                            r_col <= r_col + 4'd1;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

endmodule

>>> hw/rtl/gpq_checker.sv
// Port-level checks for groestl_permutation_pq, bound to the top level.
// Depends on groestl_permutation_pq.
module gpq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);
    // Never accept while emitting
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid)) else $error("ready during output");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // After last column is taken, loading resumes
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast |=> o_s_axis_tready)
        else $error("no return to load");

    // Non-last taken keeps output going
    a_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=> o_m_axis_tvalid)
        else $error("burst broken");
endmodule

bind groestl_permutation_pq gpq_checker u_gpq_checker (.*);
